// File: hw/rtl/thns_pkg.sv
package thns_pkg;

    localparam int STAMP_W   = 64;
    localparam int PAYLOAD_W = 64;
    localparam int TOL_W     = 32;
    localparam int CMD_W     = 2;

    localparam logic [CMD_W-1:0] CMD_PUSH  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_QUERY = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    typedef struct packed {
        logic                        valid;
        logic signed [STAMP_W-1:0]   stamp;
        logic        [PAYLOAD_W-1:0] payload;
    } slot_t;

    // controller -> datapath
    typedef struct packed {
        logic push;
        logic clear;
        logic start;
        logic step;
        logic load_out;
    } thns_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic scan_end;
    } thns_stat_t;

endpackage

// File: hw/rtl/timestamped_history_nearest_select.sv
// Channel   Direction  Handshake            Payload
// s_        in         s_valid / s_ready    s_cmd, s_entry_stamp, s_entry_valid,
//                                           s_entry_payload, s_anchor_stamp
// m_        out        m_valid / m_ready    m_found, m_match_stamp, m_match_payload
// cfg_      in         cfg_valid / cfg_ready  cfg_future_tolerance
//
// Push, clear and unused commands are taken in IDLE and leave the block in IDLE.
// A query is taken in IDLE, then reads one slot per cycle through the single read port of the
// ring store (SCAN), folds the last read word as the scan ends, passes a spare DRAIN state and
// resolves into the output register in DONE.
// Synchronous active-low reset empties the ring and zeroes the tolerance.
// A result waits in the output register; pushes and clears are still taken meanwhile,
// and a following query stalls only at its final step until the result is transferred.
module timestamped_history_nearest_select
    import thns_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [TOL_W-1:0]            cfg_future_tolerance,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [CMD_W-1:0]            s_cmd,
    input  logic signed [STAMP_W-1:0]   s_entry_stamp,
    input  logic                        s_entry_valid,
    input  logic [PAYLOAD_W-1:0]        s_entry_payload,
    input  logic signed [STAMP_W-1:0]   s_anchor_stamp,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_found,
    output logic signed [STAMP_W-1:0]   m_match_stamp,
    output logic [PAYLOAD_W-1:0]        m_match_payload
);

    thns_cmd_t  cmd;
    thns_stat_t stat;

    assign cfg_ready = 1'b1;

    thns_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_cmd   (s_cmd),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    thns_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cfg_valid            (cfg_valid),
        .cfg_future_tolerance (cfg_future_tolerance),
        .s_entry_stamp        (s_entry_stamp),
        .s_entry_valid        (s_entry_valid),
        .s_entry_payload      (s_entry_payload),
        .s_anchor_stamp       (s_anchor_stamp),
        .cmd                  (cmd),
        .stat                 (stat),
        .m_found              (m_found),
        .m_match_stamp        (m_match_stamp),
        .m_match_payload      (m_match_payload)
    );

endmodule

// File: hw/rtl/thns_ctrl.sv
module thns_ctrl
    import thns_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [CMD_W-1:0]     s_cmd,
    output logic                 m_valid,
    input  logic                 m_ready,
    input  thns_stat_t           stat,
    output thns_cmd_t            cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;
    logic       s_fire;

    assign s_ready = (state_reg == ST_IDLE);
    assign s_fire  = s_valid && s_ready;
    assign m_valid = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    unique case (s_cmd)
                        CMD_PUSH:  cmd.push = 1'b1;
                        CMD_CLEAR: cmd.clear = 1'b1;
                        CMD_QUERY: begin
                            cmd.start  = 1'b1;
                            state_next = ST_SCAN;
                        end
                        default: ;
                    endcase
                end
            end
            ST_SCAN: begin
                if (stat.scan_end) begin
                    state_next = ST_DRAIN;
                end else begin
                    cmd.step = 1'b1;
                end
            end
            // last read word was folded on the cycle the scan ended; DRAIN is a spare state before DONE
            ST_DRAIN: state_next = ST_DONE;
            ST_DONE: begin
                // hold the result until the output register is free
                if (!m_valid_reg || m_ready) begin
                    cmd.load_out = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// File: hw/rtl/thns_dpath.sv
module thns_dpath
    import thns_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_valid,
    input  logic [TOL_W-1:0]            cfg_future_tolerance,
    input  logic signed [STAMP_W-1:0]   s_entry_stamp,
    input  logic                        s_entry_valid,
    input  logic [PAYLOAD_W-1:0]        s_entry_payload,
    input  logic signed [STAMP_W-1:0]   s_anchor_stamp,
    input  thns_cmd_t                   cmd,
    output thns_stat_t                  stat,
    output logic                        m_found,
    output logic signed [STAMP_W-1:0]   m_match_stamp,
    output logic [PAYLOAD_W-1:0]        m_match_payload
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [AW-1:0] LAST_SLOT = AW'(CAPACITY - 1);
    localparam logic [CW-1:0] FULL      = CW'(CAPACITY);

    slot_t mem [CAPACITY];

    logic [AW-1:0]              wp_reg;
    logic [CW-1:0]              fill_reg;
    logic [CW-1:0]              idx_reg;
    logic [TOL_W-1:0]           tol_reg;
    logic signed [STAMP_W-1:0]  anchor_reg;
    slot_t                      rd_reg;
    logic                       rd_pend_reg;

    logic                       have_past_reg, have_fut_reg;
    logic signed [STAMP_W-1:0]  past_stamp_reg, fut_stamp_reg;
    logic [PAYLOAD_W-1:0]       past_payload_reg, fut_payload_reg;

    logic                       found_reg;
    logic signed [STAMP_W-1:0]  match_stamp_reg;
    logic [PAYLOAD_W-1:0]       match_payload_reg;

    logic                       is_past, take_past, take_fut;
    logic [STAMP_W-1:0]         fut_dist;
    logic                       fut_ok;

    assign stat.scan_end = (idx_reg == fill_reg);

    // ring store: no reset, every slot below the fill count was written since the last clear
    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            mem[wp_reg] <= '{valid: s_entry_valid, stamp: s_entry_stamp,
                             payload: s_entry_payload};
        end
        if (cmd.step) begin
            rd_reg <= mem[idx_reg[AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg      <= '0;
            fill_reg    <= '0;
            tol_reg     <= '0;
            idx_reg     <= '0;
            rd_pend_reg <= 1'b0;
        end else begin
            rd_pend_reg <= cmd.step;
            if (cfg_valid) begin
                tol_reg <= cfg_future_tolerance;
            end
            if (cmd.clear) begin
                wp_reg   <= '0;
                fill_reg <= '0;
            end else if (cmd.push) begin
                wp_reg <= (wp_reg == LAST_SLOT) ? '0 : wp_reg + 1'b1;
                if (fill_reg != FULL) begin
                    fill_reg <= fill_reg + 1'b1;
                end
            end
            if (cmd.start) begin
                idx_reg <= '0;
            end else if (cmd.step) begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
    end

    // strict compares keep the lowest slot on equal stamps
    always_comb begin
        is_past   = !(anchor_reg < rd_reg.stamp);
        take_past = rd_pend_reg && rd_reg.valid && is_past &&
                    (!have_past_reg || (past_stamp_reg < rd_reg.stamp));
        take_fut  = rd_pend_reg && rd_reg.valid && !is_past &&
                    (!have_fut_reg || (rd_reg.stamp < fut_stamp_reg));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_past_reg <= 1'b0;
            have_fut_reg  <= 1'b0;
        end else if (cmd.start) begin
            have_past_reg <= 1'b0;
            have_fut_reg  <= 1'b0;
        end else begin
            if (take_past) have_past_reg <= 1'b1;
            if (take_fut)  have_fut_reg  <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            anchor_reg <= s_anchor_stamp;
        end
        if (take_past) begin
            past_stamp_reg   <= rd_reg.stamp;
            past_payload_reg <= rd_reg.payload;
        end
        if (take_fut) begin
            fut_stamp_reg   <= rd_reg.stamp;
            fut_payload_reg <= rd_reg.payload;
        end
    end

    assign fut_dist = STAMP_W'(fut_stamp_reg) - STAMP_W'(anchor_reg);
    assign fut_ok   = have_fut_reg && (fut_dist <= {{(STAMP_W-TOL_W){1'b0}}, tol_reg});

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            if (have_past_reg) begin
                found_reg         <= 1'b1;
                match_stamp_reg   <= past_stamp_reg;
                match_payload_reg <= past_payload_reg;
            end else if (fut_ok) begin
                found_reg         <= 1'b1;
                match_stamp_reg   <= fut_stamp_reg;
                match_payload_reg <= fut_payload_reg;
            end else begin
                found_reg         <= 1'b0;
                match_stamp_reg   <= '0;
                match_payload_reg <= '0;
            end
        end
    end

    assign m_found         = found_reg;
    assign m_match_stamp   = match_stamp_reg;
    assign m_match_payload = match_payload_reg;

endmodule

// File: tb/timestamped_history_nearest_select_tb.sv
`timescale 1ns / 100ps

module timestamped_history_nearest_select_tb;
    import thns_pkg::*;

    localparam int SLOTS       = 16;
    localparam int SETTLE      = SLOTS + 8;
    localparam int HOLD_CYCLES = 400;
    localparam int LIMIT       = 300000;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    localparam longint STAMP_MIN = longint'(64'h8000_0000_0000_0000);
    localparam longint STAMP_MAX = longint'(64'h7FFF_FFFF_FFFF_FFFF);

    typedef struct packed {
        logic                        found;
        logic signed [STAMP_W-1:0]   stamp;
        logic        [PAYLOAD_W-1:0] payload;
    } match_t;

    class nearest_match_board;
        logic signed [STAMP_W-1:0]   slot_stamp [SLOTS];
        bit                          slot_valid [SLOTS];
        logic        [PAYLOAD_W-1:0] slot_payload [SLOTS];
        int unsigned                 wr_ptr;
        int unsigned                 fill;
        logic        [TOL_W-1:0]     tolerance;
        match_t                      pending_matches [$];
        int unsigned mismatches, pushes, queries, clears, hits, tol_writes;

        function new();
            clear_ring();
            tolerance = '0;
        endfunction

        function void clear_ring();
            for (int i = 0; i < SLOTS; i++) begin
                slot_stamp[i]   = '0;
                slot_valid[i]   = 1'b0;
                slot_payload[i] = '0;
            end
            wr_ptr = 0;
            fill   = 0;
        endfunction

        function void set_tolerance(input logic [TOL_W-1:0] value);
            tolerance = value;
            tol_writes++;
        endfunction

        function int pending();
            return pending_matches.size();
        endfunction

        // stamp of some filled slot, to aim queries at the interesting spots
        function longint near_stamp(input longint fallback);
            if (fill == 0)
                return fallback;
            return slot_stamp[$urandom_range(fill - 1)];
        endfunction

        function match_t select_nearest(input logic signed [STAMP_W-1:0] anchor);
            match_t              m;
            bit                  have_past;
            bit                  have_fut;
            int                  past;
            int                  fut;
            logic [STAMP_W-1:0]  gap;
            m         = '0;
            have_past = 1'b0;
            have_fut  = 1'b0;
            past      = 0;
            fut       = 0;
            for (int i = 0; i < fill; i++) begin
                if (!slot_valid[i])
                    continue;
                // strict compares keep the lowest slot on equal stamps
                if (slot_stamp[i] <= anchor) begin
                    if (!have_past || slot_stamp[past] < slot_stamp[i]) begin
                        past      = i;
                        have_past = 1'b1;
                    end
                end else if (!have_fut || slot_stamp[i] < slot_stamp[fut]) begin
                    fut      = i;
                    have_fut = 1'b1;
                end
            end
            if (have_past) begin
                m.found   = 1'b1;
                m.stamp   = slot_stamp[past];
                m.payload = slot_payload[past];
            end else if (have_fut) begin
                // later stamp is above the anchor, so the 64-bit difference is exact
                gap = slot_stamp[fut] - anchor;
                if (gap <= {32'b0, tolerance}) begin
                    m.found   = 1'b1;
                    m.stamp   = slot_stamp[fut];
                    m.payload = slot_payload[fut];
                end
            end
            return m;
        endfunction

        function void note_input(input logic [CMD_W-1:0]          cmd,
                                 input logic signed [STAMP_W-1:0] stamp,
                                 input logic                      ev,
                                 input logic [PAYLOAD_W-1:0]      payload,
                                 input logic signed [STAMP_W-1:0] anchor);
            case (cmd)
                CMD_PUSH: begin
                    pushes++;
                    slot_stamp[wr_ptr]   = stamp;
                    slot_valid[wr_ptr]   = ev;
                    slot_payload[wr_ptr] = payload;
                    wr_ptr = (wr_ptr + 1) % SLOTS;
                    if (fill < SLOTS)
                        fill++;
                end
                CMD_QUERY: begin
                    queries++;
                    pending_matches.push_back(select_nearest(anchor));
                end
                CMD_CLEAR: begin
                    clears++;
                    clear_ring();
                end
                default: ;
            endcase
        endfunction

        function void check_result(input logic                      found,
                                   input logic signed [STAMP_W-1:0] stamp,
                                   input logic [PAYLOAD_W-1:0]      payload);
            match_t want;
            if (pending_matches.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: found=%0b stamp=%0d payload=%h",
                             found, stamp, payload);
                return;
            end
            want = pending_matches.pop_front();
            if (found === 1'b1)
                hits++;
            if (found !== want.found || stamp !== want.stamp || payload !== want.payload) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"mismatch: want found=%0b stamp=%0d payload=%h, ",
                              "got found=%0b stamp=%0d payload=%h"},
                             want.found, want.stamp, want.payload, found, stamp, payload);
            end
        endfunction
    endclass

    logic                        aclk                 = 1'b0;
    logic                        aresetn              = 1'b0;
    logic                        cfg_valid            = 1'b0;
    logic                        cfg_ready;
    logic [TOL_W-1:0]            cfg_future_tolerance = '0;
    logic                        s_valid              = 1'b0;
    logic                        s_ready;
    logic [CMD_W-1:0]            s_cmd                = CMD_PUSH;
    logic signed [STAMP_W-1:0]   s_entry_stamp        = '0;
    logic                        s_entry_valid        = 1'b0;
    logic [PAYLOAD_W-1:0]        s_entry_payload      = '0;
    logic signed [STAMP_W-1:0]   s_anchor_stamp       = '0;
    logic                        m_valid;
    logic                        m_ready              = 1'b0;
    logic                        m_found;
    logic signed [STAMP_W-1:0]   m_match_stamp;
    logic [PAYLOAD_W-1:0]        m_match_payload;

    nearest_match_board board = new();

    bit no_idle     = 1'b0;
    int hold_seq    = 0;
    int cycle_count = 0;

    timestamped_history_nearest_select #(.CAPACITY(SLOTS)) DUT (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cfg_valid            (cfg_valid),
        .cfg_ready            (cfg_ready),
        .cfg_future_tolerance (cfg_future_tolerance),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_cmd                (s_cmd),
        .s_entry_stamp        (s_entry_stamp),
        .s_entry_valid        (s_entry_valid),
        .s_entry_payload      (s_entry_payload),
        .s_anchor_stamp       (s_anchor_stamp),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_found              (m_found),
        .m_match_stamp        (m_match_stamp),
        .m_match_payload      (m_match_payload)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // check results before noting a query taken on the same edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready)
                board.check_result(m_found, m_match_stamp, m_match_payload);
            if (s_valid && s_ready)
                board.note_input(s_cmd, s_entry_stamp, s_entry_valid, s_entry_payload,
                                 s_anchor_stamp);
            if (cfg_valid && cfg_ready)
                board.set_tolerance(cfg_future_tolerance);
        end
    end

    // result side: random stalls, plus a long hold-off on request
    initial begin
        int hold_seen;
        int hold_left;
        hold_seen = 0;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (hold_seq != hold_seen) begin
                hold_seen = hold_seq;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (no_idle) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= ($urandom_range(99) >= 29);
            end
        end
    end

    initial begin
        while (cycle_count < LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results outstanding", cycle_count, board.pending());
        $display("timestamped_history_nearest_select_tb: FAIL");
        $finish;
    end

    function automatic longint rand64();
        return longint'({$urandom, $urandom});
    endfunction

    function automatic longint extreme_stamp();
        case ($urandom_range(5))
            0:       return STAMP_MIN;
            1:       return STAMP_MAX;
            2:       return STAMP_MIN + 1;
            3:       return STAMP_MAX - 1;
            4:       return 0;
            default: return -1;
        endcase
    endfunction

    function automatic longint jitter(input int span);
        return longint'(int'($urandom_range(2 * span)) - span);
    endfunction

    task automatic offer(input logic [CMD_W-1:0] cmd, input longint stamp, input bit ev,
                         input logic [PAYLOAD_W-1:0] payload, input longint anchor);
        if (!no_idle) begin
            while ($urandom_range(99) < 29) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_valid         <= 1'b1;
        s_cmd           <= cmd;
        s_entry_stamp   <= stamp;
        s_entry_valid   <= ev;
        s_entry_payload <= payload;
        s_anchor_stamp  <= anchor;
        do @(posedge aclk); while (!s_ready);
    endtask

    // drop valid and hold until every query has been answered
    task automatic wait_for_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (board.pending() != 0);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_tolerance(input logic [TOL_W-1:0] value);
        cfg_valid            <= 1'b1;
        cfg_future_tolerance <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_random(input int count, input longint base);
        int     r;
        int     q;
        longint st;
        longint an;
        bit     ev;
        for (int k = 0; k < count; k++) begin
            r  = $urandom_range(99);
            q  = $urandom_range(9);
            st = rand64();
            an = rand64();
            ev = $urandom_range(1);
            if (r < 3) begin
                offer(CMD_CLEAR, st, ev, rand64(), an);
            end else if (r < 5) begin
                offer(CMD_UNUSED, st, ev, rand64(), an);
            end else if (r < 52) begin
                if (q == 1)
                    st = extreme_stamp();
                else if (q > 1)
                    st = base + jitter(2000);
                ev = ($urandom_range(9) != 0);
                offer(CMD_PUSH, st, ev, rand64(), an);
            end else begin
                if (q == 1)
                    an = extreme_stamp();
                else if (q >= 2 && q <= 5)
                    an = board.near_stamp(base) + jitter(3);
                else if (q >= 6 && q <= 8)
                    // land right around the edge of the future window
                    an = board.near_stamp(base) - longint'(board.tolerance) + jitter(2);
                else if (q == 9)
                    an = base + jitter(2500);
                offer(CMD_QUERY, st, ev, rand64(), an);
            end
        end
    endtask

    initial begin
        int               ph;
        logic [TOL_W-1:0] tol;
        longint           base;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset tolerance of zero: only exact or earlier stamps match
        offer(CMD_QUERY, 0, 1'b0, '0, 0);
        offer(CMD_PUSH, 1000, 1'b1, 64'h0123_4567_89AB_CDEF, 0);
        offer(CMD_QUERY, 0, 1'b0, '0, 999);
        offer(CMD_QUERY, 0, 1'b0, '0, 1000);
        wait_for_results();
        write_tolerance(32'd10);

        offer(CMD_PUSH, STAMP_MIN, 1'b1, '1, 0);
        offer(CMD_PUSH, STAMP_MAX, 1'b1, '0, 0);
        offer(CMD_PUSH, 2000, 1'b0, rand64(), 0);
        offer(CMD_PUSH, 1500, 1'b1, 64'hAAAA_AAAA_AAAA_AAAA, 0);
        offer(CMD_PUSH, 1500, 1'b1, 64'h5555_5555_5555_5555, 0);
        offer(CMD_QUERY, 0, 1'b0, '0, 1600);
        offer(CMD_QUERY, 0, 1'b0, '0, 2000);
        offer(CMD_QUERY, 0, 1'b0, '0, STAMP_MAX);
        offer(CMD_QUERY, 0, 1'b0, '0, STAMP_MIN);
        offer(CMD_UNUSED, rand64(), 1'b1, rand64(), rand64());
        offer(CMD_QUERY, 0, 1'b0, '0, 1499);
        offer(CMD_CLEAR, rand64(), 1'b1, rand64(), rand64());
        offer(CMD_QUERY, 0, 1'b0, '0, 0);
        offer(CMD_PUSH, 1500, 1'b1, 64'hAAAA_AAAA_AAAA_AAAA, 0);
        offer(CMD_PUSH, 1500, 1'b1, 64'h5555_5555_5555_5555, 0);
        offer(CMD_QUERY, 0, 1'b0, '0, 1490);
        offer(CMD_QUERY, 0, 1'b0, '0, 1489);
        offer(CMD_PUSH, STAMP_MAX, 1'b1, '1, 0);
        offer(CMD_QUERY, 0, 1'b0, '0, STAMP_MIN);
        wait_for_results();

        for (ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin tol = '0;                      base = rand64();        end
                1: begin tol = '1;                      base = 0;               end
                2: begin tol = $urandom;                base = STAMP_MAX - 1000; end
                3: begin tol = 32'd1000;                base = STAMP_MIN + 500; end
                4: begin tol = 32'd1;                   base = rand64();        end
                default: begin tol = $urandom_range(64); base = -1;             end
            endcase
            write_tolerance(tol);
            no_idle = (ph == 1);
            // fill the block up behind a stalled result port
            if (ph == 2)
                hold_seq++;
            send_random(105, base);
            wait_for_results();
        end

        $display("covered %0d pushes, %0d queries (%0d matched), %0d clears, %0d tol writes",
                 board.pushes, board.queries, board.hits, board.clears, board.tol_writes);
        $display("mismatches %0d, results never delivered %0d",
                 board.mismatches, board.pending());
        if (board.mismatches == 0 && board.pending() == 0)
            $display("timestamped_history_nearest_select_tb: PASS");
        else
            $display("timestamped_history_nearest_select_tb: FAIL");
        $finish;
    end

endmodule
